### hdl/i8i16dp_pkg.sv
`timescale 1ns / 1ps

package i8i16dp_pkg;

  // Word and result geometry
  localparam int WORD_W  = 64;
  localparam int DOT_W   = 32;
  localparam int PART_W  = 16;
  localparam int LANES8  = 8;
  localparam int LANES16 = 4;
  localparam int E8_W    = WORD_W / LANES8;
  localparam int E16_W   = WORD_W / LANES16;

  // Words per block
  localparam int BLOCK_WORDS_DEF = 4;

  // Element type codes (mode register)
  localparam logic ELEM_I8  = 1'b0;
  localparam logic ELEM_I16 = 1'b1;

endpackage

### hdl/int8_int16_dot_product.sv
`timescale 1ns / 1ps
// Streaming int8/int16 dot product, one word pair per cycle sustained while no
// stalled result holds the input. The last word reaches dot_o through the input reg,
// multiply, lane partials, reduction and accumulate/output reg stages.
// Throughput: 1 word per cycle; only a stalled result blocks the input.
// Reset (rst_ni low, async): partials, accumulator, position, mode and all
// valids clear.
module int8_int16_dot_product #(
  parameter int BLOCK_WORDS = i8i16dp_pkg::BLOCK_WORDS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input word channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [i8i16dp_pkg::WORD_W-1:0]        a_word_i,
  input  logic [i8i16dp_pkg::WORD_W-1:0]        b_word_i,
  input  logic                                  last_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [i8i16dp_pkg::DOT_W-1:0]  dot_o,
  // config write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  cfg_data_i
);

  localparam int POS_W   = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int WORD_W  = i8i16dp_pkg::WORD_W;
  localparam int DOT_W   = i8i16dp_pkg::DOT_W;
  localparam int PART_W  = i8i16dp_pkg::PART_W;
  localparam int LANES8  = i8i16dp_pkg::LANES8;
  localparam int LANES16 = i8i16dp_pkg::LANES16;
  localparam int NPART   = 2 * LANES8;
  localparam logic [POS_W-1:0] POS_END = POS_W'(BLOCK_WORDS - 1);

  typedef struct packed {
    logic             last;
    logic             mode;
    logic [POS_W-1:0] pos;
  } ctrl_t;

  // ---------------- config register ----------------
  logic mode_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= i8i16dp_pkg::ELEM_I8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // ---------------- handshake chain ----------------
  logic v0_q, v1_q, v2_q, v3_q, out_v_q;
  logic last2_q, last3_q;
  logic r0, r1, r2, r3;
  logic acc_take;

  // only a last word that meets a stalled result holds the pipe
  assign r3 = !v3_q || !(last3_q && out_v_q && out_stall_i);
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign r0 = !v0_q || r1;
  assign in_stall_o = !r0;
  assign acc_take   = v3_q && r3;

  // ---------------- S0: input register, word position ----------------
  logic [WORD_W-1:0] a0_q, b0_q;
  ctrl_t             c0_q;
  logic [POS_W-1:0]  pos_q;
  logic              accept;

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      pos_q <= '0;
    end else begin
      if (r0) v0_q <= in_valid_i;
      if (accept) begin
        pos_q <= (last_i || pos_q == POS_END) ? '0 : pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a0_q <= a_word_i;
      b0_q <= b_word_i;
      c0_q <= '{last: last_i, mode: mode_q, pos: pos_q};
    end
  end

  // ---------------- S1: lane products ----------------
  logic [LANES8-1:0][PART_W-1:0] p8_d, p8_q;
  logic [LANES16-1:0][DOT_W-1:0] p16_d, p16_q;
  ctrl_t                         c1_q;

  i8i16dp_mul u_mul (
    .a_word_i (a0_q),
    .b_word_i (b0_q),
    .mode_i   (c0_q.mode),
    .prod8_o  (p8_d),
    .prod16_o (p16_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (r1) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (v0_q && r1) begin
      p8_q  <= p8_d;
      p16_q <= p16_d;
      c1_q  <= c0_q;
    end
  end

  // ---------------- S2: 16-bit lane partials, block close ----------------
  logic [NPART-1:0][PART_W-1:0]  part_q, part_d, part_sum;
  logic [NPART-1:0][PART_W-1:0]  cv_q, cv_d;
  logic [LANES16-1:0][DOT_W-1:0] p16_2q;
  logic                          close1, take1;

  assign take1  = v1_q && r2;
  assign close1 = c1_q.last || c1_q.pos == POS_END;

  // even positions feed lanes 0..7, odd positions lanes 8..15
  always_comb begin
    for (int j = 0; j < NPART; j++) begin
      if (c1_q.mode == i8i16dp_pkg::ELEM_I8 && c1_q.pos[0] == (j >= LANES8)) begin
        part_sum[j] = part_q[j] + p8_q[j % LANES8];
      end else begin
        part_sum[j] = part_q[j];
      end
    end
    part_d = close1 ? '0 : part_sum;
    cv_d   = close1 ? part_sum : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      part_q <= '0;
    end else begin
      if (r2) v2_q <= v1_q;
      if (take1) part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1) begin
      cv_q    <= cv_d;
      p16_2q  <= p16_q;
      last2_q <= c1_q.last;
    end
  end

  // ---------------- S3: reduction ----------------
  logic [DOT_W-1:0] sa_d, sb_d, sc_d, sa_q, sb_q, sc_q;

  always_comb begin
    sa_d = '0;
    sb_d = '0;
    sc_d = '0;
    for (int j = 0; j < LANES8; j++) begin
      sa_d = sa_d + {{(DOT_W-PART_W){cv_q[j][PART_W-1]}}, cv_q[j]};
      sb_d = sb_d + {{(DOT_W-PART_W){cv_q[j+LANES8][PART_W-1]}}, cv_q[j+LANES8]};
    end
    for (int j = 0; j < LANES16; j++) begin
      sc_d = sc_d + p16_2q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (r3) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && r3) begin
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      sc_q    <= sc_d;
      last3_q <= last2_q;
    end
  end

  // ---------------- S4: accumulator and result register ----------------
  logic [DOT_W-1:0] acc_q, acc_sum;
  logic [DOT_W-1:0] dot_q;

  assign acc_sum = acc_q + sa_q + sb_q + sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (acc_take) acc_q <= last3_q ? '0 : acc_sum;
      if (acc_take && last3_q) out_v_q <= 1'b1;
      else if (!out_stall_i)   out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_take && last3_q) dot_q <= acc_sum;
  end

  assign out_valid_o = out_v_q;
  assign dot_o       = dot_q;

  // ---------------- assertions ----------------
`ifndef NO_ASSERTIONS
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(acc_take && last3_q))
    else $error("result word raised without a last word");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_take && last3_q) |=> (acc_q == '0))
    else $error("accumulator not cleared after last word");

  a_part_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take1 && close1) |=> (part_q == '0))
    else $error("lane partials not cleared on block close");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> (pos_q == '0))
    else $error("word position not reset after last word");
`endif

endmodule

### hdl/i8i16dp_mul.sv
`timescale 1ns / 1ps

// Lane multipliers: eight int8 products or four int16 products per word.
// The set that does not match the element type is forced to zero.
module i8i16dp_mul (
  input  logic [i8i16dp_pkg::WORD_W-1:0]                          a_word_i,
  input  logic [i8i16dp_pkg::WORD_W-1:0]                          b_word_i,
  input  logic                                                    mode_i,
  output logic [i8i16dp_pkg::LANES8-1:0][i8i16dp_pkg::PART_W-1:0] prod8_o,
  output logic [i8i16dp_pkg::LANES16-1:0][i8i16dp_pkg::DOT_W-1:0] prod16_o
);

  localparam int E8_W  = i8i16dp_pkg::E8_W;
  localparam int E16_W = i8i16dp_pkg::E16_W;

  // 8-bit lanes: signed 8x8 always fits in 16 bits
  for (genvar i = 0; i < i8i16dp_pkg::LANES8; i++) begin : g_l8
    logic signed [E8_W-1:0]                ea, eb;
    logic signed [i8i16dp_pkg::PART_W-1:0] p;
    assign ea = a_word_i[i*E8_W +: E8_W];
    assign eb = b_word_i[i*E8_W +: E8_W];
    assign p  = ea * eb;
    assign prod8_o[i] = (mode_i == i8i16dp_pkg::ELEM_I8) ? p : '0;
  end

  // 16-bit lanes: signed 16x16 fits in 32 bits
  for (genvar i = 0; i < i8i16dp_pkg::LANES16; i++) begin : g_l16
    logic signed [E16_W-1:0]              ea, eb;
    logic signed [i8i16dp_pkg::DOT_W-1:0] p;
    assign ea = a_word_i[i*E16_W +: E16_W];
    assign eb = b_word_i[i*E16_W +: E16_W];
    assign p  = ea * eb;
    assign prod16_o[i] = (mode_i == i8i16dp_pkg::ELEM_I16) ? p : '0;
  end

endmodule
